/* hw/rtl/u8cjk_pkg.sv */
// Shared types and constants for the UTF-8 decoder with CJK table classing.
`timescale 1ns / 1ps

package u8cjk_pkg;

  // Field widths
  localparam int CpW    = 31;
  localparam int LenW   = 3;
  localparam int KindW  = 2;
  localparam int ClassW = 2;
  localparam int IdxW   = 16;
  localparam int ByteW  = 8;

  // Packed stream widths (tdata padded to whole bytes)
  localparam int OutDataW = 56;
  localparam int OutUserW = KindW + ClassW;
  localparam int CfgAddrW = 2;

  // Configuration register indexes
  localparam logic [CfgAddrW-1:0] REG_IDEO_BASE  = 2'd0;
  localparam logic [CfgAddrW-1:0] REG_IDEO_COUNT = 2'd1;
  localparam logic [CfgAddrW-1:0] REG_SPECIAL_CP = 2'd2;

  // Register reset values
  localparam logic [CpW-1:0]  IDEO_BASE_RST  = 31'h0000_4E00;
  localparam logic [IdxW-1:0] IDEO_COUNT_RST = 16'd20902;
  localparam logic [CpW-1:0]  SPECIAL_CP_RST = 31'h0000_3007;

  // Sequence kinds
  localparam logic [KindW-1:0] KIND_ASCII   = 2'd0;
  localparam logic [KindW-1:0] KIND_MULTI   = 2'd1;
  localparam logic [KindW-1:0] KIND_STRAY   = 2'd2;
  localparam logic [KindW-1:0] KIND_BADLEAD = 2'd3;

  // Table classes
  localparam logic [ClassW-1:0] CLS_NONE    = 2'd0;
  localparam logic [ClassW-1:0] CLS_IDEO    = 2'd1;
  localparam logic [ClassW-1:0] CLS_SPECIAL = 2'd2;

  // Lead byte thresholds and continuation mask
  localparam logic [ByteW-1:0] LEAD_CONT = 8'h80;
  localparam logic [ByteW-1:0] LEAD_2B   = 8'hC0;
  localparam logic [ByteW-1:0] LEAD_3B   = 8'hE0;
  localparam logic [ByteW-1:0] LEAD_4B   = 8'hF0;
  localparam logic [ByteW-1:0] LEAD_5B   = 8'hF8;
  localparam logic [ByteW-1:0] LEAD_6B   = 8'hFC;
  localparam logic [ByteW-1:0] LEAD_BAD  = 8'hFE;
  localparam logic [ByteW-1:0] CONT_MASK = 8'h3F;

  // A decoded character waiting for classification
  typedef struct packed {
    logic [CpW-1:0]   cp;
    logic [LenW-1:0]  len;
    logic [KindW-1:0] kind;
  } char_t;

endpackage

/* hw/rtl/utf8_decode_cjk_index.sv */
// Top level: byte-serial UTF-8 decoder with ideograph table classing.
`timescale 1ns / 1ps

// Usage
//   in_*   : one raw UTF-8 byte per word. Lead bytes give the sequence
//            length (2 to 6); following bytes add their low six bits and
//            are not checked. 0xFE/0xFF act as six-byte leads, flagged.
//   out_*  : one word per finished character: code point, length, kind,
//            table class and table index. Lead and middle bytes give none.
//   cfg_*  : write-only registers (ideograph base, count, special code
//            point); write only while the block is idle.
// Throughput: one byte per cycle while the output is not stalled, set by the
//   single decode stage that updates the sequence state at the input handshake.
// Path: the decode register loads at the edge that accepts the byte ending a
//   character, and the classify register takes it when the output is free.
// Reset: sequence state cleared, registers back to their defaults, no
//   result pending.
// Stall: a held output word stays stable; one decoded character more can
//   wait in the decode register, after which in_tready drops.
module utf8_decode_cjk_index
  import u8cjk_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  // Input stream
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [ByteW-1:0]    in_tdata,   // [7:0] byte_in
  // Result stream
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [OutDataW-1:0] out_tdata,  // [30:0] code_point, [33:31] seq_length,
                                          // [49:34] table_index, [55:50] zero
  output logic [OutUserW-1:0] out_tuser,  // [1:0] seq_kind, [3:2] table_class
  // Configuration
  input  logic                cfg_we,
  input  logic [CfgAddrW-1:0] cfg_addr,
  input  logic [CpW-1:0]      cfg_wdata
);

  // Configuration registers
  logic [CpW-1:0]  ideo_base_r;
  logic [IdxW-1:0] ideo_count_r;
  logic [CpW-1:0]  special_cp_r;

  // Sequence state
  logic [LenW-1:0] bytes_left_r, bytes_left_nxt;
  logic [CpW-1:0]  partial_r, partial_nxt;
  logic [LenW-1:0] total_len_r, total_len_nxt;
  logic            lead_inv_r, lead_inv_nxt;

  // Decode stage
  logic  s1_valid_r;
  char_t s1_char_r;
  char_t dec_char;
  logic  dec_emit;
  logic  in_acc;
  logic  s1_adv;

  // Classify stage / output register
  logic              out_valid_r;
  logic [CpW-1:0]    out_cp_r;
  logic [LenW-1:0]   out_len_r;
  logic [KindW-1:0]  out_kind_r;
  logic [ClassW-1:0] out_class_r;
  logic [IdxW-1:0]   out_idx_r;
  logic [ClassW-1:0] cls_nxt;
  logic [IdxW-1:0]   idx_nxt;
  logic [CpW:0]      diff;

  // Handshakes
  assign s1_adv    = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_adv;
  assign in_acc    = in_tvalid && in_tready;

  // Take configuration writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ideo_base_r  <= IDEO_BASE_RST;
      ideo_count_r <= IDEO_COUNT_RST;
      special_cp_r <= SPECIAL_CP_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_IDEO_BASE:  ideo_base_r  <= cfg_wdata;
        REG_IDEO_COUNT: ideo_count_r <= cfg_wdata[IdxW-1:0];
        REG_SPECIAL_CP: special_cp_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Decode one byte against the running sequence
  always_comb begin
    bytes_left_nxt = bytes_left_r;
    partial_nxt    = partial_r;
    total_len_nxt  = total_len_r;
    lead_inv_nxt   = lead_inv_r;
    dec_emit       = 1'b0;
    dec_char.cp    = {{(CpW-ByteW){1'b0}}, in_tdata};
    dec_char.len   = LenW'(1);
    dec_char.kind  = KIND_ASCII;

    if (bytes_left_r != '0) begin
      // continuation: append six bits, unchecked
      partial_nxt    = {partial_r[CpW-7:0], in_tdata[5:0] & CONT_MASK[5:0]};
      bytes_left_nxt = bytes_left_r - LenW'(1);
      dec_emit       = (bytes_left_r == LenW'(1));
      dec_char.cp    = partial_nxt;
      dec_char.len   = total_len_r;
      dec_char.kind  = lead_inv_r ? KIND_BADLEAD : KIND_MULTI;
    end else if (in_tdata < LEAD_CONT) begin
      dec_emit = 1'b1;
    end else if (in_tdata < LEAD_2B) begin
      dec_emit      = 1'b1;
      dec_char.kind = KIND_STRAY;
    end else begin
      // lead byte: set length and keep payload bits
      lead_inv_nxt = 1'b0;
      if (in_tdata >= LEAD_6B) begin
        total_len_nxt = LenW'(6);
        partial_nxt   = CpW'(in_tdata[0]);
        lead_inv_nxt  = (in_tdata >= LEAD_BAD);
      end else if (in_tdata >= LEAD_5B) begin
        total_len_nxt = LenW'(5);
        partial_nxt   = CpW'(in_tdata[1:0]);
      end else if (in_tdata >= LEAD_4B) begin
        total_len_nxt = LenW'(4);
        partial_nxt   = CpW'(in_tdata[2:0]);
      end else if (in_tdata >= LEAD_3B) begin
        total_len_nxt = LenW'(3);
        partial_nxt   = CpW'(in_tdata[3:0]);
      end else begin
        total_len_nxt = LenW'(2);
        partial_nxt   = CpW'(in_tdata[4:0]);
      end
      bytes_left_nxt = total_len_nxt - LenW'(1);
    end
  end

  // Advance sequence state on each accepted word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bytes_left_r <= '0;
      partial_r    <= '0;
      total_len_r  <= '0;
      lead_inv_r   <= 1'b0;
    end else if (in_acc) begin
      bytes_left_r <= bytes_left_nxt;
      partial_r    <= partial_nxt;
      total_len_r  <= total_len_nxt;
      lead_inv_r   <= lead_inv_nxt;
    end
  end

  // Decode register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc) begin
      s1_valid_r <= dec_emit;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && dec_emit) begin
      s1_char_r <= dec_char;
    end
  end

  // Classify: special code point first, then the table range
  always_comb begin
    diff    = {1'b0, s1_char_r.cp} - {1'b0, ideo_base_r};
    cls_nxt = CLS_NONE;
    idx_nxt = '0;
    if (s1_char_r.cp == special_cp_r) begin
      cls_nxt = CLS_SPECIAL;
    end else if (!diff[CpW] && (diff[CpW-1:IdxW] == '0)
                 && (diff[IdxW-1:0] < ideo_count_r)) begin
      cls_nxt = CLS_IDEO;
      idx_nxt = diff[IdxW-1:0];
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_cp_r    <= s1_char_r.cp;
      out_len_r   <= s1_char_r.len;
      out_kind_r  <= s1_char_r.kind;
      out_class_r <= cls_nxt;
      out_idx_r   <= idx_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OutDataW-CpW-LenW-IdxW){1'b0}}, out_idx_r, out_len_r, out_cp_r};
  assign out_tuser  = {out_class_r, out_kind_r};

endmodule

/* hw/rtl/u8cjk_check.sv */
// Port-level checker for the UTF-8 decoder, bound to the top level.
`timescale 1ns / 1ps

module u8cjk_check
  import u8cjk_pkg::*;
(
  input logic                clk,
  input logic                rst_n,
  input logic                out_tvalid,
  input logic                out_tready,
  input logic [OutDataW-1:0] out_tdata,
  input logic [OutUserW-1:0] out_tuser
);

  // Hold a stalled result word
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result word changed");

  // No result straight after reset
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // Length is 1..6, and ASCII or stray words are single bytes of their own value
  a_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[33:31] != 3'd0 && out_tdata[33:31] != 3'd7
      && ((out_tuser[1:0] != KIND_ASCII && out_tuser[1:0] != KIND_STRAY)
          || (out_tdata[33:31] == 3'd1 && out_tdata[30:8] == '0)))
    else $error("bad sequence length");

  // Index only for ideographs, never an unused class code
  a_class: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tuser[3:2] != 2'd3
      && (out_tuser[3:2] == CLS_IDEO || out_tdata[49:34] == '0))
    else $error("bad table class or index");

  // Padding bits stay zero
  a_pad: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[55:50] == '0)
    else $error("padding bits set");

endmodule

bind utf8_decode_cjk_index u8cjk_check u_u8cjk_check (.*);

/* dv/tb_utf8_decode_cjk_index.sv */
// Self-checking testbench for the UTF-8 decoder with ideograph table classing.
`timescale 1ns / 1ps

module tb_utf8_decode_cjk_index;
  import u8cjk_pkg::*;

  // Write to an index past the last register; the block must ignore it
  localparam logic [CfgAddrW-1:0] REG_UNUSED = 2'd3;
  // Bit positions inside out_tdata
  localparam int LenLo = CpW;
  localparam int IdxLo = CpW + LenW;

  typedef struct {
    logic [CpW-1:0]    cp;
    logic [LenW-1:0]   len;
    logic [KindW-1:0]  kind;
    logic [ClassW-1:0] cls;
    logic [IdxW-1:0]   idx;
  } char_result_t;

  logic                clk;
  logic                rst_n = 1'b0;
  logic                in_tvalid = 1'b0;
  logic                in_tready;
  logic [ByteW-1:0]    in_tdata = '0;
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [OutDataW-1:0] out_tdata;
  logic [OutUserW-1:0] out_tuser;
  logic                cfg_we = 1'b0;
  logic [CfgAddrW-1:0] cfg_addr = '0;
  logic [CpW-1:0]      cfg_wdata = '0;

  // Bytes waiting to be sent and decoded characters waiting to come out
  logic [ByteW-1:0] byte_q [$];
  char_result_t     expected_chars [$];

  // Register copies used for classification
  logic [CpW-1:0]  tbl_base = IDEO_BASE_RST;
  logic [IdxW-1:0] tbl_count = IDEO_COUNT_RST;
  logic [CpW-1:0]  tbl_special = SPECIAL_CP_RST;

  // Sequence state of the decoder
  logic [LenW-1:0] left_cnt = '0;
  logic [CpW-1:0]  acc = '0;
  logic [LenW-1:0] seq_len = '0;
  logic            bad_lead = 1'b0;

  bit idle_en = 1'b1;
  int fail_cnt = 0;
  int gap_left = 0;
  int stall_left = 0;
  int hold_left = 0;
  int words_seen = 0;

  utf8_decode_cjk_index u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    fail_cnt++;
    if (fail_cnt <= 100) begin
      $display("%0t ns: %s: got %0h, want %0h", $time, what, got, want);
    end
  endtask

  // Advance the decoder by one accepted byte and queue any finished character
  task automatic decode_byte(input logic [ByteW-1:0] b);
    char_result_t ch;
    logic [CpW-1:0] offset;
    bit done;
    done = 1'b0;
    if (left_cnt != 0) begin
      // any byte counts as a continuation here, checked or not
      acc = {acc[CpW-7:0], b[5:0]};
      left_cnt = left_cnt - 1'b1;
      if (left_cnt == 0) begin
        ch.cp = acc;
        ch.len = seq_len;
        ch.kind = bad_lead ? KIND_BADLEAD : KIND_MULTI;
        done = 1'b1;
      end
    end else if (b < LEAD_CONT) begin
      ch.cp = CpW'(b);
      ch.len = 3'd1;
      ch.kind = KIND_ASCII;
      done = 1'b1;
    end else if (b < LEAD_2B) begin
      // stray continuation passes through as its own value
      ch.cp = CpW'(b);
      ch.len = 3'd1;
      ch.kind = KIND_STRAY;
      done = 1'b1;
    end else begin
      bad_lead = (b >= LEAD_BAD);
      if (b >= LEAD_6B) begin
        seq_len = 3'd6;
        acc = CpW'(b[0]);
      end else if (b >= LEAD_5B) begin
        seq_len = 3'd5;
        acc = CpW'(b[1:0]);
      end else if (b >= LEAD_4B) begin
        seq_len = 3'd4;
        acc = CpW'(b[2:0]);
      end else if (b >= LEAD_3B) begin
        seq_len = 3'd3;
        acc = CpW'(b[3:0]);
      end else begin
        seq_len = 3'd2;
        acc = CpW'(b[4:0]);
      end
      left_cnt = seq_len - 1'b1;
    end
    if (done) begin
      // special code point wins over the ideograph range
      offset = ch.cp - tbl_base;
      ch.cls = CLS_NONE;
      ch.idx = '0;
      if (ch.cp == tbl_special) begin
        ch.cls = CLS_SPECIAL;
      end else if (ch.cp >= tbl_base && offset < CpW'(tbl_count)) begin
        ch.cls = CLS_IDEO;
        ch.idx = offset[IdxW-1:0];
      end
      expected_chars = {expected_chars, ch};
    end
  endtask

  // Driver: offer queued bytes, with random gaps while idling is on
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        decode_byte(in_tdata);
      end
      if (!in_tvalid || in_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_tvalid <= 1'b0;
        end else if (byte_q.size() != 0 && idle_en && $urandom_range(0, 15) == 0) begin
          gap_left = $urandom_range(0, 11);
          in_tvalid <= 1'b0;
        end else if (byte_q.size() != 0) begin
          in_tvalid <= 1'b1;
          in_tdata <= byte_q.pop_front();
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each word against the oldest decoded character
  always @(posedge clk) begin : p_monitor
    char_result_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_chars.size() == 0) begin
          report_mismatch("word with nothing pending, code_point",
                          32'(out_tdata[CpW-1:0]), '0);
        end else begin
          want = expected_chars.pop_front();
          if (out_tdata[CpW-1:0] != want.cp)
            report_mismatch("code_point", 32'(out_tdata[CpW-1:0]), 32'(want.cp));
          if (out_tdata[LenLo +: LenW] != want.len)
            report_mismatch("seq_length", 32'(out_tdata[LenLo +: LenW]), 32'(want.len));
          if (out_tuser[KindW-1:0] != want.kind)
            report_mismatch("seq_kind", 32'(out_tuser[KindW-1:0]), 32'(want.kind));
          if (out_tuser[KindW +: ClassW] != want.cls)
            report_mismatch("table_class", 32'(out_tuser[KindW +: ClassW]),
                            32'(want.cls));
          if (out_tdata[IdxLo +: IdxW] != want.idx)
            report_mismatch("table_index", 32'(out_tdata[IdxLo +: IdxW]), 32'(want.idx));
        end
        words_seen++;
        // hold off once for a long stretch so the block backs up
        if (words_seen == 500) hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else if (idle_en && $urandom_range(0, 15) == 0) begin
        stall_left = $urandom_range(0, 11);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  task automatic push_byte(input logic [ByteW-1:0] b);
    byte_q = {byte_q, b};
  endtask

  // Encode a code point, sometimes overlong, with a few odd continuation tags
  task automatic push_char(input logic [CpW-1:0] cp);
    int n;
    int k;
    logic [31:0] v;
    logic [ByteW-1:0] lead;
    logic [1:0] tag;
    v = {1'b0, cp};
    if (v < 32'h80) n = 1;
    else if (v < 32'h800) n = 2;
    else if (v < 32'h1_0000) n = 3;
    else if (v < 32'h20_0000) n = 4;
    else if (v < 32'h400_0000) n = 5;
    else n = 6;
    if ($urandom_range(0, 3) == 0) n = $urandom_range(n, 6);
    if (n == 1) begin
      push_byte(v[7:0]);
    end else begin
      lead = 8'hFF << (8 - n);
      lead = lead | (8'(v >> (6 * (n - 1))) & (8'hFF >> (n + 1)));
      push_byte(lead);
      for (k = n - 2; k >= 0; k--) begin
        tag = ($urandom_range(0, 7) == 0) ? 2'($urandom) : LEAD_CONT[7:6];
        push_byte({tag, 6'(v >> (6 * k))});
      end
    end
  endtask

  // Aim at the edges of the table range and the special code point, or inside it or at random
  function automatic logic [CpW-1:0] pick_target();
    case ($urandom_range(0, 7))
      0: return tbl_special;
      1: return tbl_base;
      2: return tbl_base + tbl_count - 1;
      3: return tbl_base + tbl_count;
      4: return tbl_base - 1;
      7: return CpW'($urandom);
      default: return tbl_base + CpW'($urandom_range(0, tbl_count));
    endcase
  endfunction

  // Mostly well-formed characters, the rest noise and broken sequences
  task automatic fill_random(input int n_bytes);
    int start;
    int pick;
    start = byte_q.size();
    while (byte_q.size() - start < n_bytes) begin
      pick = $urandom_range(0, 99);
      if (pick < 12) begin
        push_byte(8'($urandom_range(0, 127)));
      end else if (pick < 20) begin
        push_byte(8'($urandom_range(LEAD_CONT, LEAD_2B - 1)));
      end else if (pick < 25) begin
        push_byte(8'($urandom));
      end else if (pick < 30) begin
        push_byte(LEAD_BAD | 8'($urandom_range(0, 1)));
        repeat (5) push_byte(8'($urandom));
      end else if (pick < 35) begin
        push_byte(8'($urandom_range(LEAD_2B, 8'hFF)));
        repeat ($urandom_range(1, 3)) push_byte(8'($urandom));
      end else begin
        push_char(pick_target());
      end
    end
  endtask

  // Write all registers plus the unused index; block must be idle
  task automatic set_tables(input logic [CpW-1:0] base, input logic [CpW-1:0] cnt_word,
                            input logic [CpW-1:0] spc);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= REG_IDEO_BASE;
    cfg_wdata <= base;
    @(posedge clk);
    cfg_addr <= REG_IDEO_COUNT;
    cfg_wdata <= cnt_word;
    @(posedge clk);
    cfg_addr <= REG_SPECIAL_CP;
    cfg_wdata <= spc;
    @(posedge clk);
    cfg_addr <= REG_UNUSED;
    cfg_wdata <= CpW'($urandom);
    @(posedge clk);
    cfg_we <= 1'b0;
    tbl_base = base;
    tbl_count = cnt_word[IdxW-1:0];
    tbl_special = spc;
  endtask

  // Wait until every byte is taken and every character has come out
  task automatic drain(input int settle);
    int k;
    while (byte_q.size() != 0 || in_tvalid) @(posedge clk);
    k = 0;
    while (expected_chars.size() != 0 && k < 20000) begin
      @(posedge clk);
      k++;
    end
    repeat (settle) @(posedge clk);
  endtask

  initial begin
    logic [CpW-1:0] base;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Opening bytes under reset registers: ASCII and stray extremes, shortest
    // two-byte form, first ideograph, ideographic zero, last ideograph,
    // largest four-byte value, and a 0xFF lead whose continuations include
    // an ASCII byte and a lead byte
    push_byte(8'h00); push_byte(8'h7F); push_byte(8'h80); push_byte(8'hBF);
    push_byte(8'hC0); push_byte(8'h80);
    push_byte(8'hE4); push_byte(8'hB8); push_byte(8'h80);
    push_byte(8'hE3); push_byte(8'h80); push_byte(8'h87);
    push_byte(8'hE9); push_byte(8'hBE); push_byte(8'hA5);
    push_byte(8'hF7); push_byte(8'hBF); push_byte(8'hBF); push_byte(8'hBF);
    push_byte(8'hFF); push_byte(8'h41); push_byte(8'hC3); push_byte(8'hBF);
    push_byte(8'hBF); push_byte(8'hBF);
    fill_random(300);
    drain(4);

    // Table from zero, full count, special at the top
    set_tables('0, 31'hFFFF, 31'h7FFF_FFFF);
    fill_random(300);
    drain(4);

    // Table at the top, count with upper bits to be dropped, special at zero
    set_tables(31'h7FFF_FFFF, 31'h7FFF_0010, '0);
    fill_random(300);
    drain(4);

    // Empty table
    set_tables(CpW'($urandom), '0, CpW'($urandom));
    fill_random(300);
    drain(4);

    // Special code point inside the ideograph range
    base = CpW'($urandom_range(0, 32'h3FFF_FFFF));
    set_tables(base, CpW'($urandom_range(8, 16'hFFFF)), base + 3);
    fill_random(300);
    drain(4);

    // Back to defaults, with no idling on either side
    set_tables(IDEO_BASE_RST, CpW'(IDEO_COUNT_RST), SPECIAL_CP_RST);
    idle_en = 1'b0;
    fill_random(300);
    drain(8);

    if (expected_chars.size() != 0) begin
      report_mismatch("characters never delivered", expected_chars.size(), 0);
    end
    if (fail_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #3_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
